### rtl/ubd_pkg.sv
// Package for the UART baud divisor calculator: widths, clock constants,
// prescaler shift tables, pipeline payload types and the register block.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package ubd_pkg;

    // Field widths
    localparam int BAUD_W = 24;
    localparam int PCLK_W = 24;
    localparam int WORD_W = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Datapath widths: numerator 25 * pclk < 2^29, denominator 4 * baud < 2^26
    localparam int NUM_W   = 29;
    localparam int DEN_W   = 26;
    localparam int MANT0_W = 23;   // quotient / 100 < 2^23
    localparam int RMD_W   = 7;    // remainder mod 100
    localparam int V_W     = 11;   // rmd * scale + 50 <= 1634
    localparam int F_W     = 5;    // rounded fraction, up to a full unit of 16

    // Parameter defaults
    localparam int MANTISSA_BITS_DEF = 12;
    localparam int FRACTION_BITS_DEF = 4;

    // Clock sources
    localparam logic [1:0] CLK_SRC_HSI = 2'd0;
    localparam logic [1:0] CLK_SRC_HSE = 2'd1;
    localparam logic [PCLK_W-1:0] HSI_HZ = 24'd16000000;
    localparam logic [PCLK_W-1:0] HSE_HZ = 24'd8000000;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_CLOCK_SOURCE = 3'd0;
    localparam logic [2:0] REG_AHB_PRESCALE = 3'd1;
    localparam logic [2:0] REG_APB_SLOW     = 3'd2;
    localparam logic [2:0] REG_APB_FAST     = 3'd3;
    localparam logic [2:0] REG_OVERSAMPLE   = 3'd4;

    // Arithmetic constants
    localparam logic [NUM_W-1:0] PCLK_MUL  = 29'd25;
    localparam logic [NUM_W-1:0] PCT_DIV   = 29'd100;
    localparam logic [V_W-1:0]   HALF_PCT  = 11'd50;
    // floor(q / 100) == (q * RECIP100) >> 35, exact for q < 2^30
    localparam logic [NUM_W-1:0] RECIP100  = 29'd343597384;
    localparam int               RECIP_SH  = 35;
    // floor(v / 100) == (v * FRAC_RECIP) >> 18, exact for v < 4681
    localparam logic [11:0]      FRAC_RECIP = 12'd2622;
    localparam int               FRAC_SH    = 18;

    // Configuration registers
    typedef struct packed {
        logic [1:0] clock_source;
        logic [3:0] ahb_prescale_code;
        logic [2:0] apb_slow_prescale_code;
        logic [2:0] apb_fast_prescale_code;
        logic       oversample_by_eight;
    } t_cfg;

    // Front end to divider
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [PCLK_W-1:0] pclk;
        logic              over8;
        logic              zero;
    } t_front_pay;

    // One divider step
    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;    // numerator bits still to go, quotient bits shifted in
        logic [DEN_W-1:0]  den;
        logic [PCLK_W-1:0] pclk;
        logic              over8;
        logic              zero;
    } t_div_pay;

    // Divider to mantissa/fraction split
    typedef struct packed {
        logic [NUM_W-1:0]  quo;
        logic [PCLK_W-1:0] pclk;
        logic              over8;
        logic              zero;
    } t_quo_pay;

    // Result item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ovf;
        logic [PCLK_W-1:0] pclk;
    } t_rsp_pay;

    // AHB prescaler code to right shift
    function automatic logic [3:0] ahb_shift(input logic [3:0] code);
        logic [3:0] sh;
        begin
            case (code)
                4'd8:    sh = 4'd1;
                4'd9:    sh = 4'd2;
                4'd10:   sh = 4'd3;
                4'd11:   sh = 4'd4;
                4'd12:   sh = 4'd6;
                4'd13:   sh = 4'd7;
                4'd14:   sh = 4'd8;
                4'd15:   sh = 4'd9;
                default: sh = 4'd0;
            endcase
            return sh;
        end
    endfunction

    // APB prescaler code to right shift
    function automatic logic [2:0] apb_shift(input logic [2:0] code);
        logic [2:0] sh;
        begin
            case (code)
                3'd4:    sh = 3'd1;
                3'd5:    sh = 3'd2;
                3'd6:    sh = 3'd3;
                3'd7:    sh = 3'd4;
                default: sh = 3'd0;
            endcase
            return sh;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/ubd_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on ubd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ubd_req_if import ubd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BAUD_W-1:0] baud_rate;
    logic              on_fast_bus;

    modport source (output valid, baud_rate, on_fast_bus, input ready);
    modport sink   (input valid, baud_rate, on_fast_bus, output ready);
endinterface

interface ubd_rsp_if import ubd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] divisor_word;
    logic              mantissa_overflow;
    logic [PCLK_W-1:0] bus_clock_hz;

    modport source (output valid, divisor_word, mantissa_overflow, bus_clock_hz,
                    input ready);
    modport sink   (input valid, divisor_word, mantissa_overflow, bus_clock_hz,
                    output ready);
endinterface

`default_nettype wire

### rtl/uart_baud_divisor_calc.sv
// UART baud divisor calculator, top level: APB register block, front end,
// pipelined divider, mantissa/fraction split and output skid stage.
// Depends on ubd_pkg, ubd_if, ubd_front, ubd_div, ubd_split, ubd_skid.
//
// Usage:
// - i_req carries one item per baud rate request (baud_rate, on_fast_bus);
//   o_rsp returns one result item per request, in order (divisor_word,
//   mantissa_overflow, bus_clock_hz). Both are valid/ready channels.
// - The APB port holds clock_source, AHB/APB prescaler codes and the
//   oversampling mode at byte addresses 0, 4, 8, 12, 16; pready is always
//   high. Write them only while no request is in flight.
// - Throughput: one item per cycle while o_rsp is not stalled. The pipeline is 35 stages deep
//   (2 front end, 29 divider steps of one quotient bit each, 4 split).
// - Reset clears the registers to 0 and empties the pipeline; the first
//   request can be taken in the cycle after reset is released.
// - When o_rsp stalls, the output register and a skid entry hold up to
//   two results; only then does i_req.ready drop and the pipeline freeze.
//   Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module uart_baud_divisor_calc import ubd_pkg::*; #(
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ubd_req_if.sink           i_req,
    ubd_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       en;
    logic       front_vld;
    t_front_pay front_pay;
    logic       div_vld;
    t_quo_pay   div_pay;
    logic       split_vld;
    t_rsp_pay   split_pay;
    t_rsp_pay   out_pay;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_CLOCK_SOURCE: r_cfg.clock_source           <= pwdata[1:0];
                REG_AHB_PRESCALE: r_cfg.ahb_prescale_code      <= pwdata[3:0];
                REG_APB_SLOW:     r_cfg.apb_slow_prescale_code <= pwdata[2:0];
                REG_APB_FAST:     r_cfg.apb_fast_prescale_code <= pwdata[2:0];
                REG_OVERSAMPLE:   r_cfg.oversample_by_eight    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_CLOCK_SOURCE: prdata = DATA_W'(r_cfg.clock_source);
            REG_AHB_PRESCALE: prdata = DATA_W'(r_cfg.ahb_prescale_code);
            REG_APB_SLOW:     prdata = DATA_W'(r_cfg.apb_slow_prescale_code);
            REG_APB_FAST:     prdata = DATA_W'(r_cfg.apb_fast_prescale_code);
            REG_OVERSAMPLE:   prdata = DATA_W'(r_cfg.oversample_by_eight);
            default:          prdata = '0;
        endcase
    end

    assign i_req.ready = en;

    ubd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_vld   (i_req.valid),
        .i_baud  (i_req.baud_rate),
        .i_fast  (i_req.on_fast_bus),
        .o_vld   (front_vld),
        .o_pay   (front_pay)
    );

    ubd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (front_vld),
        .i_pay   (front_pay),
        .o_vld   (div_vld),
        .o_pay   (div_pay)
    );

    ubd_split #(
        .MANTISSA_BITS (MANTISSA_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_pay   (div_pay),
        .o_vld   (split_vld),
        .o_pay   (split_pay)
    );

    ubd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (split_vld),
        .i_pay   (split_pay),
        .i_ready (o_rsp.ready),
        .o_en    (en),
        .o_vld   (o_rsp.valid),
        .o_pay   (out_pay)
    );

    assign o_rsp.divisor_word      = out_pay.word;
    assign o_rsp.mantissa_overflow = out_pay.ovf;
    assign o_rsp.bus_clock_hz      = out_pay.pclk;

    // Pipeline only freezes while a finished result is waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> o_rsp.valid)
        else $error("pipeline stalled with no result held at the output");

    // Saturated result by 16 carries an all-ones fraction
    a_sat_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.mantissa_overflow && !r_cfg.oversample_by_eight)
        |-> (o_rsp.divisor_word[FRACTION_BITS-1:0] == {FRACTION_BITS{1'b1}}))
        else $error("saturated divisor word without all-ones fraction");

    // PLL or no source gives a zero bus clock
    a_no_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_cfg.clock_source != CLK_SRC_HSI)
         && (r_cfg.clock_source != CLK_SRC_HSE))
        |-> (o_rsp.bus_clock_hz == '0))
        else $error("nonzero bus clock with no usable clock source");

endmodule

`default_nettype wire

### rtl/ubd_front.sv
// Front end: bus clock from source and prescalers, then numerator 25 * pclk
// and denominator 2 or 4 * baud. Two register stages. Depends on ubd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubd_front import ubd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_cfg              i_cfg,
    input  logic              i_vld,
    input  logic [BAUD_W-1:0] i_baud,
    input  logic              i_fast,
    output logic              o_vld,
    output t_front_pay        o_pay
);

    logic [PCLK_W-1:0] sys_hz;
    logic [2:0]        apb_code;
    logic [PCLK_W-1:0] n_a_pclk;

    logic              r_a_vld;
    logic [PCLK_W-1:0] r_a_pclk;
    logic [BAUD_W-1:0] r_a_baud;
    logic              r_a_over8;
    logic              r_a_zero;

    logic              r_b_vld;
    t_front_pay        r_b_pay;
    t_front_pay        n_b_pay;

    // Stage A: system clock through AHB and APB prescalers
    always_comb begin
        case (i_cfg.clock_source)
            CLK_SRC_HSI: sys_hz = HSI_HZ;
            CLK_SRC_HSE: sys_hz = HSE_HZ;
            default:     sys_hz = '0;
        endcase
        apb_code = i_fast ? i_cfg.apb_fast_prescale_code : i_cfg.apb_slow_prescale_code;
        n_a_pclk = (sys_hz >> ahb_shift(i_cfg.ahb_prescale_code)) >> apb_shift(apb_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pclk  <= n_a_pclk;
            r_a_baud  <= i_baud;
            r_a_over8 <= i_cfg.oversample_by_eight;
            r_a_zero  <= (i_baud == '0);
        end
    end

    // Stage B: divide operands
    always_comb begin
        n_b_pay.num   = NUM_W'(r_a_pclk) * PCLK_MUL;
        n_b_pay.den   = r_a_over8 ? (DEN_W'(r_a_baud) << 1) : (DEN_W'(r_a_baud) << 2);
        n_b_pay.pclk  = r_a_pclk;
        n_b_pay.over8 = r_a_over8;
        n_b_pay.zero  = r_a_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_pay <= n_b_pay;
        end
    end

    assign o_vld = r_b_vld;
    assign o_pay = r_b_pay;

endmodule

`default_nettype wire

### rtl/ubd_div.sv
// Pipelined restoring divider: one quotient bit per register stage,
// NUM_W stages. Depends on ubd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubd_div import ubd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_vld,
    input  t_front_pay i_pay,
    output logic       o_vld,
    output t_quo_pay   o_pay
);

    logic [NUM_W-1:0] r_vld;
    t_div_pay         r_st [NUM_W];
    t_div_pay         w_first;

    // Entry: zero remainder, whole numerator waiting
    always_comb begin
        w_first.rem   = '0;
        w_first.nq    = i_pay.num;
        w_first.den   = i_pay.den;
        w_first.pclk  = i_pay.pclk;
        w_first.over8 = i_pay.over8;
        w_first.zero  = i_pay.zero;
    end

    // Valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-2:0], i_vld};
        end
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        t_div_pay         w_cur;
        t_div_pay         n_st;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (s == 0) begin : g_head
            assign w_cur = w_first;
        end else begin : g_body
            assign w_cur = r_st[s-1];
        end

        // Shift in next numerator bit, subtract if it fits
        always_comb begin
            trial    = {w_cur.rem, w_cur.nq[NUM_W-1]};
            ge       = (trial >= {1'b0, w_cur.den});
            n_st     = w_cur;
            n_st.rem = ge ? DEN_W'(trial - {1'b0, w_cur.den}) : DEN_W'(trial);
            n_st.nq  = {w_cur.nq[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_vld       = r_vld[NUM_W-1];
    assign o_pay.quo   = r_st[NUM_W-1].nq;
    assign o_pay.pclk  = r_st[NUM_W-1].pclk;
    assign o_pay.over8 = r_st[NUM_W-1].over8;
    assign o_pay.zero  = r_st[NUM_W-1].zero;

endmodule

`default_nettype wire

### rtl/ubd_split.sv
// Splits 100x divisor into mantissa and rounded fraction, carries and
// saturates, and forms the divisor word. Four register stages. Depends on ubd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubd_split import ubd_pkg::*; #(
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_vld,
    input  t_quo_pay i_pay,
    output logic     o_vld,
    output t_rsp_pay o_pay
);

    localparam int MANT1_W = MANT0_W + 1;
    localparam int SH16    = FRACTION_BITS;
    localparam int SH8     = FRACTION_BITS - 1;
    localparam logic [F_W-1:0]     SCALE16  = F_W'(1 << SH16);
    localparam logic [F_W-1:0]     SCALE8   = F_W'(1 << SH8);
    localparam logic [MANT1_W-1:0] MANT_MAX = MANT1_W'((1 << MANTISSA_BITS) - 1);

    logic [3:0] r_vld;

    // Stage 1 signals
    logic [2*NUM_W-1:0] prod1;
    logic [MANT0_W-1:0] r_s1_mant;
    t_quo_pay           r_s1_pay;

    // Stage 2 signals
    logic [NUM_W-1:0]   hund;
    logic [RMD_W-1:0]   rmd;
    logic [V_W-1:0]     n_s2_v;
    logic [MANT0_W-1:0] r_s2_mant;
    logic [V_W-1:0]     r_s2_v;
    logic [PCLK_W-1:0]  r_s2_pclk;
    logic               r_s2_over8;
    logic               r_s2_zero;

    // Stage 3 signals
    logic [V_W+11:0]    prod3;
    logic [MANT0_W-1:0] r_s3_mant;
    logic [F_W-1:0]     r_s3_frac;
    logic [PCLK_W-1:0]  r_s3_pclk;
    logic               r_s3_over8;
    logic               r_s3_zero;

    // Stage 4 signals
    logic [F_W-1:0]     scale;
    logic               carry;
    logic [MANT1_W-1:0] mant1;
    logic [F_W-1:0]     frac1;
    logic               ovf;
    logic [MANT1_W-1:0] mant_f;
    logic [F_W-1:0]     frac_f;
    t_rsp_pay           n_s4_pay;
    t_rsp_pay           r_s4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    // Stage 1: mantissa = quotient / 100 by reciprocal multiply
    assign prod1 = (2*NUM_W)'(i_pay.quo) * (2*NUM_W)'(RECIP100);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mant <= prod1[RECIP_SH +: MANT0_W];
            r_s1_pay  <= i_pay;
        end
    end

    // Stage 2: remainder mod 100, scaled plus half for rounding
    always_comb begin
        hund   = NUM_W'(r_s1_mant) * PCT_DIV;
        rmd    = RMD_W'(r_s1_pay.quo - hund);
        n_s2_v = (r_s1_pay.over8 ? (V_W'(rmd) << SH8) : (V_W'(rmd) << SH16)) + HALF_PCT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_mant  <= r_s1_mant;
            r_s2_v     <= n_s2_v;
            r_s2_pclk  <= r_s1_pay.pclk;
            r_s2_over8 <= r_s1_pay.over8;
            r_s2_zero  <= r_s1_pay.zero;
        end
    end

    // Stage 3: fraction = v / 100 by reciprocal multiply
    assign prod3 = (V_W+12)'(r_s2_v) * (V_W+12)'(FRAC_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_mant  <= r_s2_mant;
            r_s3_frac  <= prod3[FRAC_SH +: F_W];
            r_s3_pclk  <= r_s2_pclk;
            r_s3_over8 <= r_s2_over8;
            r_s3_zero  <= r_s2_zero;
        end
    end

    // Stage 4: carry a full-unit fraction, saturate, pack the word
    always_comb begin
        scale  = r_s3_over8 ? SCALE8 : SCALE16;
        carry  = (r_s3_frac >= scale);
        mant1  = MANT1_W'(r_s3_mant) + MANT1_W'(carry);
        frac1  = carry ? '0 : r_s3_frac;
        ovf    = r_s3_zero || (mant1 > MANT_MAX);
        mant_f = ovf ? MANT_MAX : mant1;
        frac_f = ovf ? (scale - F_W'(1)) : frac1;
        n_s4_pay.word = WORD_W'((32'(mant_f) << FRACTION_BITS) | 32'(frac_f));
        n_s4_pay.ovf  = ovf;
        n_s4_pay.pclk = r_s3_pclk;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_pay <= n_s4_pay;
        end
    end

    assign o_vld = r_vld[3];
    assign o_pay = r_s4_pay;

endmodule

`default_nettype wire

### rtl/ubd_skid.sv
// Output register with a skid entry; its registered enable stalls the
// whole pipeline only when both entries are full. Depends on ubd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubd_skid import ubd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    input  t_rsp_pay i_pay,
    input  logic     i_ready,
    output logic     o_en,
    output logic     o_vld,
    output t_rsp_pay o_pay
);

    logic     r_out_vld;
    logic     r_skid_vld;
    t_rsp_pay r_out;
    t_rsp_pay r_skid;
    logic     push;
    logic     take;

    assign o_en  = !r_skid_vld;
    assign push  = o_en && i_vld;
    assign take  = r_out_vld && i_ready;

    // Control: a push only happens with the skid entry empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (push) begin
                if (!r_out_vld || take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (take) begin
                if (r_skid_vld) begin
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_vld || take) begin
                r_out <= i_pay;
            end else begin
                r_skid <= i_pay;
            end
        end else if (take && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_vld = r_out_vld;
    assign o_pay = r_out;

endmodule

`default_nettype wire

### tb/uart_baud_divisor_calc_test.sv
// Self-checking testbench for uart_baud_divisor_calc: predicts each divisor word,
// overflow flag and bus clock from the mirrored register settings and compares.
// Depends on ubd_pkg, ubd_if and the RTL of uart_baud_divisor_calc.
`timescale 1ns / 1ps

module uart_baud_divisor_calc_test import ubd_pkg::*; ();

    // Clock sources the package does not name
    localparam logic [1:0] CLK_SRC_PLL  = 2'd2;
    localparam logic [1:0] CLK_SRC_NONE = 2'd3;

    localparam int MANT_BITS    = MANTISSA_BITS_DEF;
    localparam int FRAC_BITS    = FRACTION_BITS_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [BAUD_W-1:0] BAUD_MAX = '1;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ubd_req_if req_ch ();
    ubd_rsp_if rsp_ch ();

    uart_baud_divisor_calc dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the register block and results still owed by the block
    t_cfg     bus_cfg;
    t_rsp_pay divisor_queue[$];

    bit steady;               // no idling on either side
    int hold_off_cycles;      // one long result stall, taken by the result sink
    int mismatches;
    int requests_taken;
    int results_checked;
    int saturated_seen;
    int no_clock_seen;
    int settings_applied;
    int idle_cycles;

    int unsigned std_bauds[15] = '{1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200,
                                   230400, 460800, 921600, 2000000, 3000000, 4500000,
                                   10500000};

    always #5 i_clk = ~i_clk;

    // Expected result for one request under the given settings
    function automatic t_rsp_pay predict_divisor(input logic [BAUD_W-1:0] baud,
                                                 input logic fast, input t_cfg cfg);
        longint unsigned sys_hz, pclk, den, quot, mant, frac, scale, mant_max;
        int unsigned     ahb_sh, apb_sh;
        logic [2:0]      apb_code;
        logic            ovf;
        t_rsp_pay        res;
        case (cfg.clock_source)
            CLK_SRC_HSI: sys_hz = HSI_HZ;
            CLK_SRC_HSE: sys_hz = HSE_HZ;
            default:     sys_hz = 0;
        endcase
        // AHB codes 8..11 shift by 1..4, codes 12..15 by 6..9 (no divide by 32)
        if (cfg.ahb_prescale_code < 4'd8)
            ahb_sh = 0;
        else if (cfg.ahb_prescale_code < 4'd12)
            ahb_sh = cfg.ahb_prescale_code - 7;
        else
            ahb_sh = cfg.ahb_prescale_code - 6;
        apb_code = fast ? cfg.apb_fast_prescale_code : cfg.apb_slow_prescale_code;
        apb_sh   = (apb_code < 3'd4) ? 0 : apb_code - 3;
        pclk     = (sys_hz >> ahb_sh) >> apb_sh;
        scale    = cfg.oversample_by_eight ? (64'd1 << (FRAC_BITS - 1)) : (64'd1 << FRAC_BITS);
        mant_max = (64'd1 << MANT_BITS) - 1;
        ovf      = 1'b0;
        if (baud == '0) begin
            // zero rate reads as an infinite divisor
            ovf  = 1'b1;
            mant = mant_max;
            frac = scale - 1;
        end else begin
            den  = cfg.oversample_by_eight ? 2 * longint'(baud) : 4 * longint'(baud);
            quot = (25 * pclk) / den;
            mant = quot / 100;
            frac = ((quot % 100) * scale + 50) / 100;
            // rounding up to a full unit carries into the mantissa
            if (frac >= scale) begin
                frac = 0;
                mant = mant + 1;
            end
            if (mant > mant_max) begin
                ovf  = 1'b1;
                mant = mant_max;
                frac = scale - 1;
            end
        end
        res.word = 16'(((mant << FRAC_BITS) | frac) & 64'hFFFF);
        res.ovf  = ovf;
        res.pclk = pclk[PCLK_W-1:0];
        return res;
    endfunction

    // Baud rate mix: standard rates, tiny rates that may saturate, whole field range
    function automatic logic [BAUD_W-1:0] draw_baud();
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            return '0;
        else if (pick < 6)
            return BAUD_W'($urandom_range(1, 400));
        else if (pick < 14)
            return BAUD_W'($urandom);
        else if (pick < 28)
            return BAUD_W'(std_bauds[$urandom_range(0, 14)] + $urandom_range(0, 2) - 1);
        else
            return BAUD_W'($urandom_range(1200, 10500000));
    endfunction

    // Record each accepted request with its prediction
    always @(posedge i_clk) begin : request_monitor
        t_rsp_pay exp_res;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            exp_res = predict_divisor(req_ch.baud_rate, req_ch.on_fast_bus, bus_cfg);
            divisor_queue.push_back(exp_res);
            requests_taken++;
            if (exp_res.ovf)
                saturated_seen++;
            if (exp_res.pclk == '0)
                no_clock_seen++;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_rsp_pay exp_res;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (divisor_queue.size() == 0) begin
                $error("result with no request outstanding: word %h", rsp_ch.divisor_word);
                mismatches++;
            end else begin
                exp_res = divisor_queue.pop_front();
                results_checked++;
                if (rsp_ch.divisor_word !== exp_res.word) begin
                    $error("divisor_word: expected %h, got %h", exp_res.word,
                           rsp_ch.divisor_word);
                    mismatches++;
                end
                if (rsp_ch.mantissa_overflow !== exp_res.ovf) begin
                    $error("mantissa_overflow: expected %b, got %b", exp_res.ovf,
                           rsp_ch.mantissa_overflow);
                    mismatches++;
                end
                if (rsp_ch.bus_clock_hz !== exp_res.pclk) begin
                    $error("bus_clock_hz: expected %0d, got %0d", exp_res.pclk,
                           rsp_ch.bus_clock_hz);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink: random stall per item, or one long hold-off on request
    initial begin : result_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge i_clk);
        end
    end

    // One request item; valid stays high afterwards unless the next one idles
    task automatic send_request(input logic [BAUD_W-1:0] baud, input logic fast);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.baud_rate   <= baud;
        req_ch.on_fast_bus <= fast;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (divisor_queue.size() != 0) @(posedge i_clk);
    endtask

    // APB write, setup then access; unused upper data bits carry junk
    task automatic write_register(input logic [2:0] index, input logic [DATA_W-1:0] value,
                                  input int width);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= (junk << width) | value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (index)
            REG_CLOCK_SOURCE: bus_cfg.clock_source           = value[1:0];
            REG_AHB_PRESCALE: bus_cfg.ahb_prescale_code      = value[3:0];
            REG_APB_SLOW:     bus_cfg.apb_slow_prescale_code = value[2:0];
            REG_APB_FAST:     bus_cfg.apb_fast_prescale_code = value[2:0];
            REG_OVERSAMPLE:   bus_cfg.oversample_by_eight    = value[0];
            default: ;
        endcase
    endtask

    // Program all registers; only called with nothing in flight
    task automatic set_config(input logic [1:0] src, input logic [3:0] ahb,
                              input logic [2:0] slow, input logic [2:0] fast,
                              input logic over8);
        write_register(REG_CLOCK_SOURCE, DATA_W'(src), 2);
        write_register(REG_AHB_PRESCALE, DATA_W'(ahb), 4);
        write_register(REG_APB_SLOW, DATA_W'(slow), 3);
        write_register(REG_APB_FAST, DATA_W'(fast), 3);
        write_register(REG_OVERSAMPLE, DATA_W'(over8), 1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        settings_applied++;
    endtask

    task automatic random_config();
        logic [1:0] src;
        src = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
        set_config(src, 4'($urandom), 3'($urandom), 3'($urandom), 1'($urandom));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_request(draw_baud(), 1'($urandom));
    endtask

    // Reset settings: field extremes, carry, saturation edge
    task automatic test_reset_settings();
        send_request('0, 1'b0);
        send_request('0, 1'b1);
        send_request(24'd1, 1'b0);
        send_request(BAUD_MAX, 1'b1);
        send_request(24'd10500000, 1'b0);
        send_request(24'd115200, 1'b1);
        send_request(24'd9600, 1'b0);
        send_request(24'd1000003, 1'b0);   // quotient 99: fraction rounds to a full unit
        send_request(24'd244, 1'b1);       // mantissa 4098 saturates
        send_request(24'd245, 1'b0);       // mantissa 4081 just fits
        wait_for_results();
    endtask

    // Oversampling by 8: 3-bit fraction, carry and saturation
    task automatic test_oversample_by_eight();
        set_config(CLK_SRC_HSI, 4'd0, 3'd0, 3'd0, 1'b1);
        send_request(24'd2000003, 1'b1);   // quotient 99 carries with scale 8
        send_request(24'd122, 1'b0);
        send_request('0, 1'b1);
        send_request(BAUD_MAX, 1'b0);
        wait_for_results();
    endtask

    // No-clock sources, crystal and deepest prescalers on each bus
    task automatic test_clock_sources();
        set_config(CLK_SRC_PLL, 4'd0, 3'd0, 3'd0, 1'b0);
        send_request(24'd9600, 1'b0);
        wait_for_results();
        set_config(CLK_SRC_NONE, 4'd15, 3'd7, 3'd7, 1'b1);
        send_request(24'd115200, 1'b1);
        wait_for_results();
        set_config(CLK_SRC_HSE, 4'd15, 3'd7, 3'd0, 1'b0);
        send_request(24'd1, 1'b0);
        send_request(24'd9600, 1'b1);
        wait_for_results();
        set_config(CLK_SRC_HSI, 4'd12, 3'd4, 3'd7, 1'b1);
        send_request(24'd300, 1'b0);
        send_request(24'd300, 1'b1);
        wait_for_results();
    endtask

    // Random items over several settings, the extremes first
    task automatic test_random_settings();
        set_config(CLK_SRC_HSE, 4'd15, 3'd7, 3'd7, 1'b1);
        send_random(60);
        wait_for_results();
        set_config(CLK_SRC_HSI, 4'd0, 3'd0, 3'd0, 1'b0);
        send_random(80);
        wait_for_results();
        repeat (5) begin
            random_config();
            send_random(60);
            wait_for_results();
        end
    endtask

    // Back-to-back items with no idling on either side
    task automatic test_steady_stream();
        set_config(CLK_SRC_HSI, 4'($urandom), 3'($urandom), 3'($urandom), 1'b0);
        steady = 1'b1;
        send_random(80);
        wait_for_results();
        steady = 1'b0;
    endtask

    // Long result stall while requests keep coming, so the input backs up
    task automatic test_output_stall();
        random_config();
        hold_off_cycles = 150;
        send_random(80);
        wait_for_results();
    endtask

    // Bursts separated by a full drain
    task automatic test_sender_pause();
        random_config();
        repeat (3) begin
            send_random(25);
            wait_for_results();
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        bus_cfg     = '0;
        steady      = 1'b0;
        idle_cycles = 0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.baud_rate   <= '0;
        req_ch.on_fast_bus <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_oversample_by_eight();
        test_clock_sources();
        test_random_settings();
        test_steady_stream();
        test_output_stall();
        test_sender_pause();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d requests across %0d register settings;",
                 results_checked, requests_taken, settings_applied);
        $display("%0d saturated divisors, %0d requests with no bus clock.",
                 saturated_seen, no_clock_seen);
        if (mismatches == 0 && divisor_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
